@@ hw/rtl/bdq_pkg.sv @@
`timescale 1ns / 1ps

package bdq_pkg;

  // Operation codes carried by the action field
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_SEARCH     = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_APPEND
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POST
  } state_t;

endpackage

@@ hw/rtl/bdq_cell.sv @@
`timescale 1ns / 1ps

module bdq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bdq_pkg::cell_cmd_t    cmd,
  input  logic [DATA_WIDTH-1:0] ins,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid
);
  import bdq_pkg::*;

  logic [DATA_WIDTH-1:0] data_next;
  logic                  valid_next;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    case (cmd)
      CELL_FROM_LEFT: begin
        data_next  = left_data;
        valid_next = left_valid;
      end
      CELL_FROM_RIGHT: begin
        data_next  = right_data;
        valid_next = right_valid;
      end
      CELL_APPEND: begin
        // first free slot: empty here, occupied on the left
        if (!valid && left_valid) begin
          data_next  = ins;
          valid_next = 1'b1;
        end
      end
      default: begin
        data_next  = data;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    data <= data_next;
  end

endmodule

@@ hw/rtl/bounded_deque_with_search.sv @@
// Bounded deque held in a chain of DEPTH cells, entries packed from cell 0 (front).
// Push front/back, pops on empty, pop front and unused codes: written to the result
// register, one transfer per cycle when the result side keeps up.
// Membership test and pop back on a non-empty queue: the ring rotates once through
// all DEPTH cells in S_SCAN, then S_POST writes the result; requests stall meanwhile.
// Synchronous active-high rst empties the queue and drops any pending result.
`timescale 1ns / 1ps

module bounded_deque_with_search #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [2:0]                   action,
  input  logic [DATA_WIDTH-1:0]        value,
  // response channel
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [DATA_WIDTH-1:0]        popped,
  output logic                         found,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output logic [1:0]                   status
);
  import bdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // control state
  state_t             state, state_next;
  logic [CNT_W-1:0]   fill_count, fill_count_next;
  logic [IDX_W-1:0]   step;

  // scan context, loaded when a rotation starts
  logic                  scan_pop;
  logic                  scan_found;
  logic [DATA_WIDTH-1:0] scan_popped;
  logic [DATA_WIDTH-1:0] scan_value;

  // cell chain
  cell_cmd_t             cell_cmd;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic                  wrap_valid;
  logic                  kill;

  // handshake and sequencing
  logic accept;
  logic out_free;
  logic scan_run;
  logic post_now;
  logic post_acc;
  logic start_scan;
  logic is_full;
  logic is_empty;
  logic [1:0]            acc_status;
  logic [DATA_WIDTH-1:0] acc_popped;

  assign out_free = !rsp_valid || !rsp_stall;
  assign accept   = req_valid && !req_stall;
  assign is_full  = (fill_count == CNT_W'(DEPTH));
  assign is_empty = (fill_count == '0);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start_scan) state_next = S_SCAN;
      end
      S_SCAN: begin
        // last rotation step puts every cell back at its home position
        if (step == IDX_W'(DEPTH - 1)) state_next = S_POST;
      end
      S_POST: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req_stall = 1'b1;
    scan_run  = 1'b0;
    post_now  = 1'b0;
    case (state)
      S_IDLE: req_stall = rsp_valid && rsp_stall;
      S_SCAN: scan_run  = 1'b1;
      S_POST: post_now  = out_free;
      default: req_stall = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Operation decode and chain command
  // ---------------------------------------------------------------------------
  always_comb begin
    cell_cmd        = CELL_HOLD;
    fill_count_next = fill_count;
    start_scan      = 1'b0;
    post_acc        = 1'b0;
    acc_status      = ST_OK;
    acc_popped      = '0;
    kill            = 1'b0;
    wrap_valid      = 1'b0;

    if (accept) begin
      case (action)
        ACT_PUSH_FRONT: begin
          post_acc = 1'b1;
          if (is_full) begin
            acc_status = ST_FULL;
          end else begin
            cell_cmd        = CELL_FROM_LEFT;
            fill_count_next = fill_count + 1'b1;
          end
        end
        ACT_PUSH_BACK: begin
          post_acc = 1'b1;
          if (is_full) begin
            acc_status = ST_FULL;
          end else begin
            cell_cmd        = CELL_APPEND;
            fill_count_next = fill_count + 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          post_acc = 1'b1;
          if (is_empty) begin
            acc_status = ST_EMPTY;
          end else begin
            // shift toward the front, an empty slot enters at the back
            cell_cmd        = CELL_FROM_RIGHT;
            acc_popped      = cell_data[0];
            fill_count_next = fill_count - 1'b1;
          end
        end
        ACT_POP_BACK: begin
          if (is_empty) begin
            post_acc   = 1'b1;
            acc_status = ST_EMPTY;
          end else begin
            // back entry is dropped as it passes cell 0 during the rotation
            start_scan      = 1'b1;
            fill_count_next = fill_count - 1'b1;
          end
        end
        ACT_SEARCH: begin
          start_scan = 1'b1;
        end
        default: begin
          post_acc = 1'b1;
        end
      endcase
    end

    if (scan_run) begin
      // rotate: cell 0 wraps to the last cell; at step s cell 0 holds entry s.
      // fill_count already holds the reduced count, which is the back's index.
      cell_cmd   = CELL_FROM_RIGHT;
      kill       = scan_pop && (CNT_W'(step) == fill_count);
      wrap_valid = cell_valid[0] && !kill;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_data;
    logic                  l_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_valid;

    if (i == 0) begin : g_head
      assign l_data  = value;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_data  = cell_data[0];
      assign r_valid = wrap_valid;
    end else begin : g_mid_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    bdq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cell_cmd),
      .ins         (value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      if (post_acc || post_now) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // scan context and step counter
  always_ff @(posedge clk) begin
    if (start_scan) begin
      step        <= '0;
      scan_found  <= 1'b0;
      scan_popped <= '0;
      scan_pop    <= (action == ACT_POP_BACK);
      scan_value  <= value;
    end else if (scan_run) begin
      step <= step + 1'b1;
      // pop back ignores its value word, so only a search can report a hit
      if (!scan_pop && cell_valid[0] && (cell_data[0] == scan_value)) scan_found <= 1'b1;
      if (kill) scan_popped <= cell_data[0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (post_acc) begin
      popped <= acc_popped;
      found  <= 1'b0;
      count  <= fill_count_next;
      status <= acc_status;
    end else if (post_now) begin
      popped <= scan_popped;
      found  <= scan_found;
      count  <= fill_count;
      status <= ST_OK;
    end
  end

endmodule

@@ hw/rtl/bdq_checker.sv @@
`timescale 1ns / 1ps

module bdq_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_stall,
  input logic [2:0]                   action,
  input logic [DATA_WIDTH-1:0]        value,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input logic [DATA_WIDTH-1:0]        popped,
  input logic                         found,
  input logic [$clog2(DEPTH+1)-1:0]   count,
  input logic [1:0]                   status
);
  import bdq_pkg::*;

  // a held result keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(popped) && $stable(count))
    else $error("response changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> count <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("count beyond depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> count == ($clog2(DEPTH+1))'(DEPTH))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> count == '0 && popped == '0 && !found)
    else $error("empty status with entries or data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind bounded_deque_with_search bdq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_bdq_checker (.*);
